### hw/rtl/ncw_pkg.sv
// ----------------------------------------------------------------------------
// ncw_pkg : shared definitions for the nibble canvas
// Canvas geometry, field widths, request codes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package ncw_pkg;

    // Canvas geometry
    localparam int ROW_COUNT     = 64;
    localparam int WORDS_PER_ROW = 8;

    // Fixed field widths
    localparam int WORD_W = 32;
    localparam int PIX_W  = 4;
    localparam int TYPE_W = 3;
    localparam int IDX_W  = 9;

    localparam int ROW_BITS     = WORD_W * WORDS_PER_ROW;
    localparam int ROW_W        = $clog2(ROW_COUNT);
    localparam int COL_W        = $clog2(WORDS_PER_ROW);
    localparam int CANVAS_WORDS = ROW_COUNT * WORDS_PER_ROW;

    // Reciprocal of WORDS_PER_ROW scaled by 2**IDX_W; the estimate it gives
    // is the true row or one less
    localparam int SPLIT_RECIP = (1 << IDX_W) / WORDS_PER_ROW;

    // Stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = TYPE_W + IDX_W + WORD_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = WORD_W + 1;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [TYPE_W-1:0] {
        REQ_WRITE = 3'd0,
        REQ_READ  = 3'd1,
        REQ_UP    = 3'd2,
        REQ_DOWN  = 3'd3,
        REQ_LEFT  = 3'd4,
        REQ_RIGHT = 3'd5,
        REQ_FLIP  = 3'd6
    } req_type_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_LOCATE,
        ST_HRD,
        ST_HOLD,
        ST_RD,
        ST_WR,
        ST_LAST,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### hw/rtl/ncw_ram.sv
// ----------------------------------------------------------------------------
// ncw_ram : generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ncw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/nibble_canvas_wrap_scroll_flip.sv
// ----------------------------------------------------------------------------
// nibble_canvas_wrap_scroll_flip : 4-bit pixel canvas with wrap scroll and flip
// Canvas rows live in one row-wide memory; a sequencer reads, modifies and
// writes back one row at a time for word writes, scrolls and mirroring.
//
//   channel | dir | tdata fields (lowest bit first)             | transfer
//   s_*     | in  | req_type[2:0] word_index[11:3] write_word   | tvalid & tready
//           |     |   [43:12], zero pad [47:44]                 |
//   m_*     | out | read_word[31:0] op_done[32], zero pad       | tvalid & tready
//
// Rows up/down, pixels left/right and flip visit every row; each row costs a
//   read then a write through the single read and single write port.
// Reset: a clearing pass zeroes the memory one row at a time, s_tready low.
// Stalls: a new request is taken only in idle; a finished result waits in
//   the output register, and the sequencer holds if that register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module nibble_canvas_wrap_scroll_flip (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // req_type[2:0], word_index[11:3], write_word[43:12], pad
    input  logic [ncw_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // read_word[31:0], op_done[32], pad
    output logic [ncw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import ncw_pkg::*;

    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(ROW_COUNT - 1);
    localparam logic [ROW_W-1:0] HALF_LAST = ROW_W'(ROW_COUNT / 2 - 1);
    localparam logic [ROW_W-1:0] ONE_ROW   = ROW_W'(1);

    state_t              state_reg, state_next;
    req_type_t           op_reg, op_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [WORD_W-1:0]   wword_reg, wword_next;
    logic [ROW_W-1:0]    cnt_reg, cnt_next;
    logic [ROW_W-1:0]    row_est_reg, row_est_next;
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_BITS-1:0] hold_reg, hold_next;
    logic [WORD_W-1:0]   rd_word_reg, rd_word_next;
    logic                done_reg, done_next;
    logic                m_tvalid_reg, m_tvalid_next;
    logic [OUT_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr;
    logic [ROW_BITS-1:0] ram_wdata;
    logic [ROW_W-1:0]    ram_raddr;
    logic [ROW_BITS-1:0] ram_rdata;

    req_type_t           in_type;
    logic [IDX_W-1:0]    in_idx;
    logic [WORD_W-1:0]   in_word;
    logic                in_range;

    logic [2*IDX_W-1:0]  est_prod;
    logic [IDX_W:0]      est_base;
    logic [IDX_W:0]      rem;
    logic [ROW_W-1:0]    loc_row;
    logic [COL_W-1:0]    loc_col;

    logic [ROW_W-1:0]    src_row;
    logic [ROW_W-1:0]    hold_row;
    logic [ROW_W-1:0]    last_row;
    logic [ROW_BITS-1:0] merged_row;
    logic [ROW_BITS-1:0] rot_left;
    logic [ROW_BITS-1:0] rot_right;

    ncw_ram #(
        .WIDTH(ROW_BITS),
        .DEPTH(ROW_COUNT)
    ) u_rows (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign in_type  = req_type_t'(s_tdata[TYPE_W-1:0]);
    assign in_idx   = s_tdata[TYPE_W +: IDX_W];
    assign in_word  = s_tdata[TYPE_W+IDX_W +: WORD_W];
    assign in_range = (32'(in_idx) < 32'(CANVAS_WORDS));

    // Row and column of a word index: reciprocal estimate, then one correction
    assign est_prod = (2*IDX_W)'(idx_reg) * (2*IDX_W)'(SPLIT_RECIP);
    assign est_base = (IDX_W+1)'(row_est_reg * WORDS_PER_ROW);
    assign rem      = {1'b0, idx_reg} - est_base;

    always_comb
    begin
        if (rem >= (IDX_W+1)'(WORDS_PER_ROW))
        begin
            loc_row = row_est_reg + ONE_ROW;
            loc_col = COL_W'(rem - (IDX_W+1)'(WORDS_PER_ROW));
        end
        else
        begin
            loc_row = row_est_reg;
            loc_col = COL_W'(rem);
        end
    end

    // Row addresses per operation; cnt_reg is the destination row
    always_comb
    begin
        case (op_reg)
            REQ_UP:
            begin
                src_row  = cnt_reg + ONE_ROW;
                hold_row = '0;
                last_row = LAST_ROW;
            end
            REQ_DOWN:
            begin
                src_row  = cnt_reg - ONE_ROW;
                hold_row = LAST_ROW;
                last_row = '0;
            end
            REQ_FLIP:
            begin
                src_row  = LAST_ROW - cnt_reg;
                hold_row = cnt_reg;
                last_row = LAST_ROW - cnt_reg;
            end
            default:
            begin
                src_row  = cnt_reg;
                hold_row = cnt_reg;
                last_row = cnt_reg;
            end
        endcase
    end

    always_comb
    begin
        merged_row = ram_rdata;
        for (int k = 0; k < WORDS_PER_ROW; k++)
        begin
            if (COL_W'(k) == col_reg)
            begin
                merged_row[k*WORD_W +: WORD_W] = wword_reg;
            end
        end
    end

    // Leftmost pixel sits in the lowest nibble of the row
    assign rot_left  = {ram_rdata[PIX_W-1:0], ram_rdata[ROW_BITS-1:PIX_W]};
    assign rot_right = {ram_rdata[ROW_BITS-PIX_W-1:0], ram_rdata[ROW_BITS-1:ROW_BITS-PIX_W]};

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        idx_next      = idx_reg;
        wword_next    = wword_reg;
        cnt_next      = cnt_reg;
        row_est_next  = row_est_reg;
        col_next      = col_reg;
        hold_next     = hold_reg;
        rd_word_next  = rd_word_reg;
        done_next     = done_reg;
        m_tdata_next  = m_tdata_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        s_tready      = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = cnt_reg;
        ram_wdata     = ram_rdata;
        ram_raddr     = src_row;

        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                if (cnt_reg == LAST_ROW)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ONE_ROW;
                end
            end

            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op_next      = in_type;
                    idx_next     = in_idx;
                    wword_next   = in_word;
                    rd_word_next = '0;
                    done_next    = 1'b1;
                    cnt_next     = '0;
                    case (in_type)
                        REQ_WRITE, REQ_READ:
                        begin
                            if (in_range)
                            begin
                                state_next = ST_SPLIT;
                            end
                            else
                            begin
                                done_next  = 1'b0;
                                state_next = ST_RESP;
                            end
                        end
                        REQ_UP, REQ_FLIP:
                        begin
                            state_next = ST_HRD;
                        end
                        REQ_DOWN:
                        begin
                            cnt_next   = LAST_ROW;
                            state_next = ST_HRD;
                        end
                        REQ_LEFT, REQ_RIGHT:
                        begin
                            state_next = ST_RD;
                        end
                        default:
                        begin
                            done_next  = 1'b0;
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end

            ST_SPLIT:
            begin
                row_est_next = ROW_W'(est_prod >> IDX_W);
                state_next   = ST_LOCATE;
            end

            ST_LOCATE:
            begin
                cnt_next   = loc_row;
                col_next   = loc_col;
                ram_raddr  = loc_row;
                state_next = ST_WR;
            end

            ST_HRD:
            begin
                ram_raddr  = hold_row;
                state_next = ST_HOLD;
            end

            // Capture the row that gets overwritten first, fetch the source
            ST_HOLD:
            begin
                hold_next  = ram_rdata;
                state_next = ST_WR;
            end

            ST_RD:
            begin
                state_next = ST_WR;
            end

            ST_WR:
            begin
                case (op_reg)
                    REQ_WRITE:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = merged_row;
                        state_next = ST_RESP;
                    end
                    REQ_READ:
                    begin
                        rd_word_next = ram_rdata[col_reg*WORD_W +: WORD_W];
                        state_next   = ST_RESP;
                    end
                    REQ_LEFT, REQ_RIGHT:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = (op_reg == REQ_LEFT) ? rot_left : rot_right;
                        if (cnt_reg == LAST_ROW)
                        begin
                            state_next = ST_RESP;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + ONE_ROW;
                            state_next = ST_RD;
                        end
                    end
                    REQ_UP:
                    begin
                        ram_we = 1'b1;
                        if (cnt_reg == LAST_ROW - ONE_ROW)
                        begin
                            state_next = ST_LAST;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg + ONE_ROW;
                            state_next = ST_RD;
                        end
                    end
                    REQ_DOWN:
                    begin
                        ram_we = 1'b1;
                        if (cnt_reg == ONE_ROW)
                        begin
                            state_next = ST_LAST;
                        end
                        else
                        begin
                            cnt_next   = cnt_reg - ONE_ROW;
                            state_next = ST_RD;
                        end
                    end
                    REQ_FLIP:
                    begin
                        ram_we     = 1'b1;
                        state_next = ST_LAST;
                    end
                    default:
                    begin
                        state_next = ST_RESP;
                    end
                endcase
            end

            // Drop the held row into the slot left open
            ST_LAST:
            begin
                ram_we    = 1'b1;
                ram_waddr = last_row;
                ram_wdata = hold_reg;
                if (op_reg == REQ_FLIP && cnt_reg != HALF_LAST)
                begin
                    cnt_next   = cnt_reg + ONE_ROW;
                    state_next = ST_HRD;
                end
                else
                begin
                    state_next = ST_RESP;
                end
            end

            ST_RESP:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = OUT_TDATA_W'({done_reg, rd_word_reg});
                    state_next    = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            cnt_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        idx_reg     <= idx_next;
        wword_reg   <= wword_next;
        row_est_reg <= row_est_next;
        col_reg     <= col_next;
        hold_reg    <= hold_next;
        rd_word_reg <= rd_word_next;
        done_reg    <= done_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

### hw/rtl/ncw_chk.sv
// ----------------------------------------------------------------------------
// ncw_chk : port-level checks for the nibble canvas
// Watches the stream ports of the top level; attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module ncw_chk (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic [ncw_pkg::IN_TDATA_W-1:0]  s_tdata,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [ncw_pkg::OUT_TDATA_W-1:0] m_tdata
);

    import ncw_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Pad bits above the result fields stay zero
    a_out_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_TDATA_W-1:OUT_FIELDS_W] == '0)
        else $error("result pad bits not zero");

    // A request that was not carried out returns no data
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[WORD_W] |-> m_tdata[WORD_W-1:0] == '0)
        else $error("read word nonzero on failed request");

    // Requests are taken one at a time
    a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule

bind nibble_canvas_wrap_scroll_flip ncw_chk u_ncw_chk (.*);

`default_nettype wire

### tb/nibble_canvas_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nibble_canvas_checker : result predictor and comparator for the canvas
// Keeps its own image of the 4-bit pixel canvas, applies every request
// transfer to it, and compares each result transfer field by field with the
// oldest predicted reply.
// ----------------------------------------------------------------------------
module nibble_canvas_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // req_type[2:0], word_index[11:3], write_word[43:12], pad
    input  logic [ncw_pkg::IN_TDATA_W-1:0]  s_tdata,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // read_word[31:0], op_done[32], pad
    input  logic [ncw_pkg::OUT_TDATA_W-1:0] m_tdata,
    output int                              mismatches,
    output int                              outstanding
);
    import ncw_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              done;
    } canvas_reply_t;

    logic [WORD_W-1:0] canvas_image [CANVAS_WORDS];
    canvas_reply_t     awaited [$];
    canvas_reply_t     seen;
    canvas_reply_t     want;
    int                errors = 0;

    // Row r takes old row src(r); covers up, down and the top-bottom mirror
    task automatic move_rows(input logic [TYPE_W-1:0] kind);
        logic [WORD_W-1:0] prior [CANVAS_WORDS];
        int src;
        prior = canvas_image;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            if (kind == REQ_UP)
                src = (r + 1) % ROW_COUNT;
            else if (kind == REQ_DOWN)
                src = (r + ROW_COUNT - 1) % ROW_COUNT;
            else
                src = ROW_COUNT - 1 - r;
            for (int c = 0; c < WORDS_PER_ROW; c++)
                canvas_image[r * WORDS_PER_ROW + c] = prior[src * WORDS_PER_ROW + c];
        end
    endtask

    // Rotate each row as one wide value; the lowest nibble is the leftmost pixel
    task automatic rotate_pixels(input bit leftward);
        logic [ROW_BITS-1:0] line;
        for (int r = 0; r < ROW_COUNT; r++)
        begin
            for (int c = 0; c < WORDS_PER_ROW; c++)
                line[c * WORD_W +: WORD_W] = canvas_image[r * WORDS_PER_ROW + c];
            if (leftward)
                line = {line[PIX_W-1:0], line[ROW_BITS-1:PIX_W]};
            else
                line = {line[ROW_BITS-PIX_W-1:0], line[ROW_BITS-1 -: PIX_W]};
            for (int c = 0; c < WORDS_PER_ROW; c++)
                canvas_image[r * WORDS_PER_ROW + c] = line[c * WORD_W +: WORD_W];
        end
    endtask

    task automatic apply_request(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                 input logic [WORD_W-1:0] data, output canvas_reply_t reply);
        reply.word = '0;
        reply.done = 1'b1;
        case (kind)
            REQ_WRITE:
            begin
                if (idx < CANVAS_WORDS)
                    canvas_image[idx] = data;
                else
                    reply.done = 1'b0;
            end
            REQ_READ:
            begin
                if (idx < CANVAS_WORDS)
                    reply.word = canvas_image[idx];
                else
                    reply.done = 1'b0;
            end
            REQ_UP, REQ_DOWN, REQ_FLIP: move_rows(kind);
            REQ_LEFT:                   rotate_pixels(1'b1);
            REQ_RIGHT:                  rotate_pixels(1'b0);
            default:                    reply.done = 1'b0;
        endcase
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            foreach (canvas_image[i])
                canvas_image[i] = '0;
            awaited.delete();
        end
        else
        begin
            // Check the result side first so a result cannot match a request
            // taken at the same edge
            if (m_tvalid && m_tready)
            begin
                seen.word = m_tdata[WORD_W-1:0];
                seen.done = m_tdata[WORD_W];
                if (awaited.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, got read_word %h op_done %b",
                             $time, seen.word, seen.done);
                    errors++;
                end
                else
                begin
                    want = awaited.pop_front();
                    if (seen.word !== want.word)
                    begin
                        $display("%0t: read_word mismatch, expected %h, got %h",
                                 $time, want.word, seen.word);
                        errors++;
                    end
                    if (seen.done !== want.done)
                    begin
                        $display("%0t: op_done mismatch, expected %b, got %b",
                                 $time, want.done, seen.done);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                apply_request(s_tdata[TYPE_W-1:0], s_tdata[TYPE_W +: IDX_W],
                              s_tdata[TYPE_W+IDX_W +: WORD_W], want);
                awaited.push_back(want);
            end
        end
        mismatches  <= errors;
        outstanding <= awaited.size();
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top : stream testbench for the nibble canvas
// Drives directed and random word writes, reads, scrolls and flips with
// random gaps on the request side and random stalls on the result side;
// the checker predicts every result and counts mismatches.
// ----------------------------------------------------------------------------
module tb_top;
    import ncw_pkg::*;

    localparam logic [TYPE_W-1:0] REQ_UNDEFINED = 3'd7;
    localparam int RANDOM_REQUESTS = 1750;
    localparam int DRAIN_CYCLES    = 200;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    int                     mismatches;
    int                     outstanding;

    int quiet_left = 0;
    int stall_left = 0;
    int calm_left  = 0;
    int dice;

    nibble_canvas_wrap_scroll_flip dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    nibble_canvas_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // Mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(30, 80);
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_request(input logic [TYPE_W-1:0] kind,
                                                            input logic [IDX_W-1:0] idx,
                                                            input logic [WORD_W-1:0] word);
        logic [IN_TDATA_W-1:0] beat;
        beat = '0;
        beat[TYPE_W-1:0]             = kind;
        beat[TYPE_W +: IDX_W]        = idx;
        beat[TYPE_W+IDX_W +: WORD_W] = word;
        return beat;
    endfunction

    // Favor the first and last rows and word columns, where the wraps happen
    function automatic logic [IDX_W-1:0] pick_index();
        int row;
        int col;
        case ($urandom_range(0, 3))
            0:       row = 0;
            1:       row = ROW_COUNT - 1;
            default: row = $urandom_range(0, ROW_COUNT - 1);
        endcase
        case ($urandom_range(0, 3))
            0:       col = 0;
            1:       col = WORDS_PER_ROW - 1;
            default: col = $urandom_range(0, WORDS_PER_ROW - 1);
        endcase
        return IDX_W'(row * WORDS_PER_ROW + col);
    endfunction

    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    function automatic logic [TYPE_W-1:0] pick_kind();
        int r;
        r = $urandom_range(0, 99);
        if (r < 38) return REQ_WRITE;
        if (r < 76) return REQ_READ;
        if (r < 80) return REQ_UP;
        if (r < 84) return REQ_DOWN;
        if (r < 88) return REQ_LEFT;
        if (r < 92) return REQ_RIGHT;
        if (r < 96) return REQ_FLIP;
        return REQ_UNDEFINED;
    endfunction

    // Called at a rising edge; returns at the edge where the transfer happens
    task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [IDX_W-1:0] idx,
                                input logic [WORD_W-1:0] word);
        int gap;
        if (quiet_left > 0)
        begin
            gap = 0;
            quiet_left--;
        end
        else
        begin
            gap = pick_gap();
            if ($urandom_range(0, 99) < 3)
                quiet_left = $urandom_range(20, 60);
        end
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= pack_request(TYPE_W'($urandom), IDX_W'($urandom), $urandom);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pack_request(kind, idx, word);
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Hold the request side until every predicted result has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
    endtask

    // Result side: random stalls, with calm stretches of steady ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else if (calm_left > 0)
        begin
            calm_left--;
            m_tready <= 1'b1;
        end
        else
        begin
            dice = $urandom_range(0, 99);
            if (dice < 4)
            begin
                calm_left = $urandom_range(50, 300);
                m_tready <= 1'b1;
            end
            else if (dice < 24)
            begin
                stall_left = pick_gap();
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corner words, every operation, undefined request type
        send_request(REQ_WRITE, 9'd0, 32'hFFFF_FFFF);
        send_request(REQ_WRITE, 9'd7, 32'h1234_5678);
        send_request(REQ_WRITE, 9'd504, 32'h0000_000A);
        send_request(REQ_WRITE, 9'd511, 32'hF000_0001);
        send_request(REQ_READ, 9'd0, 32'h0);
        send_request(REQ_READ, 9'd511, 32'hFFFF_FFFF);
        send_request(REQ_LEFT, 9'd0, 32'h0);
        send_request(REQ_READ, 9'd0, 32'h0);
        send_request(REQ_READ, 9'd7, 32'h0);
        send_request(REQ_READ, 9'd511, 32'h0);
        send_request(REQ_RIGHT, 9'd511, 32'h0);
        send_request(REQ_READ, 9'd504, 32'h0);
        send_request(REQ_UP, 9'd0, 32'h0);
        send_request(REQ_READ, 9'd504, 32'h0);
        send_request(REQ_READ, 9'd0, 32'h0);
        send_request(REQ_DOWN, 9'd0, 32'h0);
        send_request(REQ_FLIP, 9'd0, 32'h0);
        send_request(REQ_READ, 9'd7, 32'h0);
        send_request(REQ_READ, 9'd511, 32'h0);
        send_request(REQ_UNDEFINED, 9'd0, 32'hDEAD_BEEF);
        send_request(REQ_UNDEFINED, 9'd511, 32'h0);
        send_request(REQ_WRITE, 9'd256, 32'h0);
        send_request(REQ_READ, 9'd256, 32'h0);
        send_request(REQ_READ, 9'd255, 32'h0);
        wait_drained();

        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            send_request(pick_kind(), pick_index(), pick_word());
            if (n % 500 == 499)
                wait_drained();
        end
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

### nibble_canvas_wrap_scroll_flip.f
hw/rtl/ncw_pkg.sv
hw/rtl/ncw_ram.sv
hw/rtl/nibble_canvas_wrap_scroll_flip.sv
hw/rtl/ncw_chk.sv
tb/nibble_canvas_checker.sv
tb/tb_top.sv
